FILE: rtl/core/tip_pkg.sv
`default_nettype none
package tip_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int REG_W           = 31;

   localparam logic [REG_W-1:0] MAJOR_RESET = 31'd655360;
   localparam logic [REG_W-1:0] MINOR_RESET = 31'd131072;

   localparam logic CSR_MAJOR = 1'b0;
   localparam logic CSR_MINOR = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_AXIS     = 2'd1,
      STATUS_BACKBONE = 2'd2
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/core/tip_sqrt_pipe.sv
`default_nettype none
// Floor square root, one root bit per register stage.
module tip_sqrt_pipe #(
   parameter int ROOT_W = 32,
   parameter int SIDE_W = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [2*ROOT_W-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0]     in_side,
   output logic                       out_valid,
   output logic [ROOT_W-1:0]          out_root,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic [ROOT_W-1:0] valid_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [REM_W+1:0]  rem_sh;
      logic [REM_W+1:0]  trial;
      logic              take;
      logic [REM_W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = in_rad;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign rem_sh = {rem_prev, rad_prev[RAD_W-1 -: 2]};
      assign trial  = (REM_W+2)'({root_prev, 2'b01});
      assign take   = rem_sh >= trial;
      assign rem_in = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {root_prev[ROOT_W-2:0], take};
            rad_ff[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/core/tip_div_pipe.sv
`default_nettype none
// Two-lane restoring divider sharing one divisor, one quotient bit per stage.
// The quotient must fit in Q_W bits.
module tip_div_pipe #(
   parameter int NUM_W  = 64,
   parameter int DEN_W  = 32,
   parameter int Q_W    = 32,
   parameter int SIDE_W = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [NUM_W-1:0]   in_num_a,
   input  wire logic [NUM_W-1:0]   in_num_b,
   input  wire logic [DEN_W-1:0]   in_den,
   input  wire logic [SIDE_W-1:0]  in_side,
   output logic                    out_valid,
   output logic [Q_W-1:0]          out_quo_a,
   output logic [Q_W-1:0]          out_quo_b,
   output logic [SIDE_W-1:0]       out_side
);

   logic [DEN_W-1:0]  rem_ff  [Q_W][2];
   logic [Q_W-1:0]    sh_ff   [Q_W][2];
   logic [DEN_W-1:0]  den_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];
   logic [Q_W-1:0]    valid_ff;

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [DEN_W-1:0]  rem_prev [2];
      logic [Q_W-1:0]    sh_prev  [2];
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [DEN_W-1:0]  rem_in   [2];
      logic [Q_W-1:0]    sh_in    [2];

      if (k == 0) begin : g_first
         assign rem_prev[0] = DEN_W'(in_num_a >> Q_W);
         assign rem_prev[1] = DEN_W'(in_num_b >> Q_W);
         assign sh_prev[0]  = in_num_a[Q_W-1:0];
         assign sh_prev[1]  = in_num_b[Q_W-1:0];
         assign den_prev    = in_den;
         assign side_prev   = in_side;
         assign valid_prev  = in_valid;
      end else begin : g_next
         assign rem_prev[0] = rem_ff[k-1][0];
         assign rem_prev[1] = rem_ff[k-1][1];
         assign sh_prev[0]  = sh_ff[k-1][0];
         assign sh_prev[1]  = sh_ff[k-1][1];
         assign den_prev    = den_ff[k-1];
         assign side_prev   = side_ff[k-1];
         assign valid_prev  = valid_ff[k-1];
      end

      // shift register carries the unused numerator bits down and quotient bits in
      always_comb begin
         logic [DEN_W:0] trial;
         logic           take;
         for (int l = 0; l < 2; l++) begin
            trial     = {rem_prev[l], sh_prev[l][Q_W-1]};
            take      = trial >= {1'b0, den_prev};
            rem_in[l] = take ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
            sh_in[l]  = {sh_prev[l][Q_W-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[k][l] <= rem_in[l];
               sh_ff[k][l]  <= sh_in[l];
            end
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_quo_a = sh_ff[Q_W-1][0];
   assign out_quo_b = sh_ff[Q_W-1][1];
   assign out_side  = side_ff[Q_W-1];

endmodule
`default_nettype wire

FILE: rtl/core/torus_inside_and_project_unit.sv
`default_nettype none
// Channel   Dir  Handshake               Payload
// req       in   req_tvalid/req_tready   tdata: pos_x, pos_y, pos_z
// rsp       out  rsp_tvalid/rsp_tready   tdata: is_inside, proj_x, proj_y, proj_z; tuser: status
// csr       in   csr_valid/csr_ready     csr_index, csr_wdata (low 31 bits kept)
//
// One item per cycle while the response is not held. The pipeline has
// COORD_WIDTH + max(COORD_WIDTH, 31) + 74 register stages (138 at 32-bit coordinates), set by
// two bit-per-stage square roots and two bit-per-stage dividers of 31 and 32 quotient bits.
// Reset is synchronous; it clears valid bits and loads the default radii.
// A held result freezes the whole pipeline; req_tready drops in the same cycle.
module torus_inside_and_project_unit #(
   parameter int COORD_WIDTH = tip_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,   // pos_x, pos_y, pos_z
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // is_inside, proj_x, proj_y, proj_z
   output logic [((3 * COORD_WIDTH + 1 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [1:0]                    rsp_tuser,   // status
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic                     csr_index,
   input  wire logic [31:0]              csr_wdata
);

   localparam int W          = COORD_WIDTH;
   localparam int REQ_DATA_W = ((3 * W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((3 * W + 1 + 7) / 8) * 8;
   localparam int RW         = tip_pkg::REG_W;
   localparam int D_W        = (W > RW) ? W : RW;
   localparam int L_W        = D_W + 1;
   localparam int PT_W       = RW + D_W;
   localparam int SM_W       = RW + 1;
   localparam int PX_W       = W + SM_W;
   localparam int SAT_W      = ((SM_W > W) ? SM_W : W) + 1;

   typedef struct packed {
      logic           xn;
      logic           yn;
      logic           zn;
      logic [W-1:0]   xm;
      logic [W-1:0]   ym;
      logic [W-1:0]   zm;
      logic [W-1:0]   q;
      logic           qzero;
      logic           dneg;
      logic [D_W-1:0] dm;
      logic           in_tube;
      logic           lzero;
      logic [RW-1:0]  pz;
      logic           sneg;
      logic [SM_W-1:0] sm;
   } item_type;

   localparam int IT_W = $bits(item_type);

   // configuration
   logic [RW-1:0]   major_ff;
   logic [RW-1:0]   minor_ff;
   logic [2*RW-1:0] rr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff <= tip_pkg::MAJOR_RESET;
         minor_ff <= tip_pkg::MINOR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tip_pkg::CSR_MAJOR: major_ff <= csr_wdata[RW-1:0];
            tip_pkg::CSR_MINOR: minor_ff <= csr_wdata[RW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rr_ff <= (2*RW)'(minor_ff) * (2*RW)'(minor_ff);
   end

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 0: sign and magnitude
   logic [W-1:0] pos_x, pos_y, pos_z;
   item_type     it0_in, it0_ff;
   logic         v0_ff;

   assign pos_x = req_tdata[W-1:0];
   assign pos_y = req_tdata[2*W-1:W];
   assign pos_z = req_tdata[3*W-1:2*W];

   always_comb begin
      it0_in    = '0;
      it0_in.xn = pos_x[W-1];
      it0_in.yn = pos_y[W-1];
      it0_in.zn = pos_z[W-1];
      it0_in.xm = pos_x[W-1] ? W'(-pos_x) : pos_x;
      it0_in.ym = pos_y[W-1] ? W'(-pos_y) : pos_y;
      it0_in.zm = pos_z[W-1] ? W'(-pos_z) : pos_z;
   end

   // stage 1: squares, stage 2: radius sum
   item_type       it1_ff, it2_ff;
   logic [2*W-1:0] sqx_ff, sqy_ff, rad_ff;
   logic           v1_ff, v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it0_ff <= it0_in;
         it1_ff <= it0_ff;
         sqx_ff <= (2*W)'(it0_ff.xm) * (2*W)'(it0_ff.xm);
         sqy_ff <= (2*W)'(it0_ff.ym) * (2*W)'(it0_ff.ym);
         it2_ff <= it1_ff;
         rad_ff <= sqx_ff + sqy_ff;
      end
   end

   logic         v3;
   logic [W-1:0] q3;
   item_type     it3;

   tip_sqrt_pipe #(.ROOT_W(W), .SIDE_W(IT_W)) u_sqrt_xy (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v2_ff), .in_rad(rad_ff), .in_side(it2_ff),
      .out_valid(v3), .out_root(q3), .out_side(it3)
   );

   // stage 4: distance from backbone radius
   item_type it4_in, it4_ff;
   logic     v4_ff;

   always_comb begin
      it4_in       = it3;
      it4_in.q     = q3;
      it4_in.qzero = q3 == '0;
      it4_in.dneg  = D_W'(q3) < D_W'(major_ff);
      it4_in.dm    = it4_in.dneg ? D_W'(major_ff) - D_W'(q3) : D_W'(q3) - D_W'(major_ff);
   end

   // stage 5: squares, stage 6: tube distance squared and containment test
   item_type         it5_ff, it6_in, it6_ff;
   logic [2*D_W-1:0] sqd_ff;
   logic [2*W-1:0]   sqz_ff;
   logic [2*L_W-1:0] dd_in, dd_ff;
   logic             v5_ff, v6_ff;

   always_comb begin
      dd_in          = (2*L_W)'(sqd_ff) + (2*L_W)'(sqz_ff);
      it6_in         = it5_ff;
      it6_in.in_tube = dd_in <= (2*L_W)'(rr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it4_ff <= it4_in;
         it5_ff <= it4_ff;
         sqd_ff <= (2*D_W)'(it4_ff.dm) * (2*D_W)'(it4_ff.dm);
         sqz_ff <= (2*W)'(it4_ff.zm) * (2*W)'(it4_ff.zm);
         it6_ff <= it6_in;
         dd_ff  <= dd_in;
      end
   end

   logic           v7;
   logic [L_W-1:0] len7;
   item_type       it7;

   tip_sqrt_pipe #(.ROOT_W(L_W), .SIDE_W(IT_W)) u_sqrt_tube (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v6_ff), .in_rad(dd_ff), .in_side(it6_ff),
      .out_valid(v7), .out_root(len7), .out_side(it7)
   );

   // stage 7: numerators for the tube scaling
   item_type        it8_in, it8_ff;
   logic [PT_W-1:0] num_t_ff, num_z_ff;
   logic [L_W-1:0]  len_ff;
   logic            v8_ff;

   always_comb begin
      it8_in       = it7;
      it8_in.lzero = len7 == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it8_ff   <= it8_in;
         len_ff   <= len7;
         num_t_ff <= PT_W'(minor_ff) * PT_W'(it7.dm);
         num_z_ff <= PT_W'(minor_ff) * PT_W'(it7.zm);
      end
   end

   logic          v9;
   logic [RW-1:0] tm9, pz9;
   item_type      it9;

   tip_div_pipe #(.NUM_W(PT_W), .DEN_W(L_W), .Q_W(RW), .SIDE_W(IT_W)) u_div_tube (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v8_ff), .in_num_a(num_t_ff), .in_num_b(num_z_ff),
      .in_den(len_ff), .in_side(it8_ff),
      .out_valid(v9), .out_quo_a(tm9), .out_quo_b(pz9), .out_side(it9)
   );

   // stage 8: radial distance of the surface point
   item_type      it10_in, it10_ff;
   logic [RW-1:0] tm_eff;
   logic          v10_ff;

   always_comb begin
      tm_eff  = it9.lzero ? '0 : tm9;
      it10_in = it9;
      it10_in.pz = it9.lzero ? '0 : pz9;
      if (!it9.dneg) begin
         it10_in.sneg = 1'b0;
         it10_in.sm   = SM_W'(major_ff) + SM_W'(tm_eff);
      end else if (tm_eff > major_ff) begin
         it10_in.sneg = 1'b1;
         it10_in.sm   = SM_W'(tm_eff) - SM_W'(major_ff);
      end else begin
         it10_in.sneg = 1'b0;
         it10_in.sm   = SM_W'(major_ff) - SM_W'(tm_eff);
      end
   end

   // stage 9: numerators for the XY scaling
   item_type        it11_ff;
   logic [PX_W-1:0] num_x_ff, num_y_ff;
   logic            v11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (en) begin
         v10_ff <= v9;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it10_ff  <= it10_in;
         it11_ff  <= it10_ff;
         num_x_ff <= PX_W'(it10_ff.xm) * PX_W'(it10_ff.sm);
         num_y_ff <= PX_W'(it10_ff.ym) * PX_W'(it10_ff.sm);
      end
   end

   logic            v12;
   logic [SM_W-1:0] px12, py12;
   item_type        it12;

   tip_div_pipe #(.NUM_W(PX_W), .DEN_W(W), .Q_W(SM_W), .SIDE_W(IT_W)) u_div_xy (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v11_ff), .in_num_a(num_x_ff), .in_num_b(num_y_ff),
      .in_den(it11_ff.q), .in_side(it11_ff),
      .out_valid(v12), .out_quo_a(px12), .out_quo_b(py12), .out_side(it12)
   );

   function automatic logic [W-1:0] sat(input logic neg, input logic [SM_W-1:0] mag);
      logic [SAT_W-1:0] m;
      logic [SAT_W-1:0] maxp;
      logic [SAT_W-1:0] lim;
      m    = SAT_W'(mag);
      maxp = SAT_W'({1'b0, {(W-1){1'b1}}});
      lim  = maxp + SAT_W'(1);
      if (!neg) begin
         sat = (m > maxp) ? W'(maxp) : W'(m);
      end else begin
         if (m > lim) begin
            m = lim;
         end
         sat = W'(~m + SAT_W'(1));
      end
   endfunction

   // output register
   logic                out_v_ff;
   logic                in_tube_ff, in_tube_in;
   logic [W-1:0]        px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   tip_pkg::status_type status_ff, status_in;

   always_comb begin
      if (it12.qzero) begin
         status_in  = tip_pkg::STATUS_AXIS;
         in_tube_in = 1'b0;
         px_in      = '0;
         py_in      = '0;
         pz_in      = '0;
      end else begin
         status_in  = it12.lzero ? tip_pkg::STATUS_BACKBONE : tip_pkg::STATUS_OK;
         in_tube_in = it12.in_tube;
         px_in      = sat(it12.xn ^ it12.sneg, px12);
         py_in      = sat(it12.yn ^ it12.sneg, py12);
         pz_in      = sat(it12.zn, SM_W'(it12.pz));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= v12;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_tube_ff <= in_tube_in;
         px_ff      <= px_in;
         py_ff      <= py_in;
         pz_ff      <= pz_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = RSP_DATA_W'({pz_ff, py_ff, px_ff, in_tube_ff});
   assign rsp_tuser  = status_ff;

   // an item on the Z axis carries no inside flag and a zero projection
   a_axis_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tip_pkg::STATUS_AXIS) |->
         (rsp_tdata == '0))
      else $error("axis item with nonzero payload");

   // a point on the backbone is inside and projects to z of zero
   a_backbone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tip_pkg::STATUS_BACKBONE) |->
         (rsp_tdata[0] && pz_ff == '0))
      else $error("backbone item with bad inside flag or z");

   // no status code beyond the backbone code ever leaves the block
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == tip_pkg::STATUS_OK ||
                      rsp_tuser == tip_pkg::STATUS_AXIS ||
                      rsp_tuser == tip_pkg::STATUS_BACKBONE))
      else $error("bad status code");

endmodule
`default_nettype wire
